// ===== rtl/core/clr_pkg.sv =====
// Shared types and constants for the channel latency ranker.
// No dependencies; used by clr_cell and channel_latency_ranker_core.
package clr_pkg;

  localparam int MaxProbesDef = 64;
  localparam int TimeBitsDef  = 26;

  localparam logic [31:0] NoReplyTime = 32'd999999;
  localparam logic [9:0]  NoReplyLoss = 10'd1000;
  localparam logic [31:0] ScoreMax    = 32'hFFFF_FFFF;
  localparam logic [3:0]  ChanHigh    = 4'd11;
  localparam logic [3:0]  ChanLow     = 4'd1;

  // Control shared by every cell of the sample chain.
  typedef struct packed {
    logic ins;    // insert the new time in sorted place
    logic shift;  // move every value one cell toward cell 0
  } cell_ctl_t;

endpackage

// ===== rtl/core/clr_cell.sv =====
// One cell of the sorted sample chain: holds one reply time.
// Depends on clr_pkg for the chain control struct.
module clr_cell #(
  parameter int TIME_BITS = clr_pkg::TimeBitsDef,
  parameter int CW        = 7,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  clr_pkg::cell_ctl_t   ctl_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic [TIME_BITS-1:0] new_i,
  input  logic [TIME_BITS-1:0] left_val_i,
  input  logic                 left_gt_i,
  input  logic [TIME_BITS-1:0] right_val_i,
  output logic [TIME_BITS-1:0] val_o,
  output logic                 gt_o
);

  logic [TIME_BITS-1:0] val_q;
  logic                 below;
  logic                 at_end;

  assign below  = CW'(IDX) < cnt_i;
  assign at_end = CW'(IDX) == cnt_i;
  // The first empty slot counts as larger than anything.
  assign gt_o   = at_end | (below & (val_q > new_i));
  assign val_o  = val_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      val_q <= right_val_i;
    end else if (ctl_i.ins && gt_o) begin
      val_q <= left_gt_i ? left_val_i : new_i;
    end
  end

endmodule

// ===== rtl/core/clr_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// No package dependencies.
module clr_div #(
  parameter int NW = 28,
  parameter int DW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int KW = $clog2(NW + 1);

  logic          run_q, done_q;
  logic [KW-1:0] cnt_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_q;
  logic [DW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q[DW-1:0], num_q[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + KW'(1);
        if (cnt_q == KW'(NW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== rtl/core/channel_latency_ranker_core.sv =====
// Top level of the channel latency ranker: probe counting, sorted sample
// chain, percentile pick, serial loss divide and best-channel tracking.
// Depends on clr_pkg, clr_cell and clr_div.
//
// Channel  | Direction | Handshake                     | Payload
// ---------+-----------+-------------------------------+---------------------------------
// probe    | in        | start high while busy low     | chan_num, reply_seen, rtt_us,
//          |           |                               | last_probe, last_channel
// result   | out       | result_valid_o, one cycle     | metric_chan, median_time, p95_time,
//          |           |                               | loss_pm, quality_score, run_done,
//          |           |                               | best_chan
//
// A plain probe beat is taken without leaving idle; an end-of-run beat
// without metrics gives its result the next cycle. A last-probe beat with
// replies walks the sorted chain down to the 95th percentile index, then
// runs the loss divide while the median weight comes from a reciprocal
// multiply, then forms the score; one with no replies goes straight to the
// score. Reset is asynchronous; the sample chain needs no clearing since
// only cells below the receive count are read. The result beat cannot be
// stalled by the receiver.
module channel_latency_ranker_core #(
  parameter int MAX_PROBES = clr_pkg::MaxProbesDef,
  parameter int TIME_BITS  = clr_pkg::TimeBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [3:0]           chan_num_i,
  input  logic                 reply_seen_i,
  input  logic [TIME_BITS-1:0] rtt_us_i,
  input  logic                 last_probe_i,
  input  logic                 last_channel_i,
  output logic                 result_valid_o,
  output logic [3:0]           metric_chan_o,
  output logic [TIME_BITS-1:0] median_time_o,
  output logic [TIME_BITS-1:0] p95_time_o,
  output logic [9:0]           loss_pm_o,
  output logic [31:0]          quality_score_o,
  output logic                 run_done_o,
  output logic [3:0]           best_chan_o
);

  localparam int CW  = $clog2(MAX_PROBES + 1);
  localparam int IW  = $clog2(MAX_PROBES);
  localparam int DW  = (CW > 4) ? CW : 4;
  localparam int LW  = CW + 10;
  localparam int NW  = LW;
  localparam int PW  = CW + 19;
  // 95/100 as 95 * 5243 / 2^19, exact over the count range
  localparam int PctMul = 498085;
  // 3/10 rounded up over 2^KT: exact floor for every TIME_BITS-wide median
  localparam int KT  = TIME_BITS + 4;
  localparam int MW  = TIME_BITS + 3;
  localparam int QW  = TIME_BITS + MW;
  localparam logic [MW-1:0] MedWeight = MW'(((64'd3 << KT) + 64'd9) / 64'd10);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StShift = 3'd1;
  localparam logic [2:0] StDivL  = 3'd2;
  localparam logic [2:0] StFin   = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        scnt_q, rcnt_q;
  logic [31:0]          low_score_q;
  logic [3:0]           best_chan_q;
  logic [3:0]           chan_q;
  logic                 lastc_q, nr_q;
  logic [IW-1:0]        k_q;
  logic [TIME_BITS-1:0] med_q, p95_q, mq_q;
  logic [9:0]           loss_q;

  logic                 out_vld_q, out_done_q;
  logic [3:0]           out_mchan_q, out_best_q;
  logic [TIME_BITS-1:0] out_med_q, out_p95_q;
  logic [9:0]           out_loss_q;
  logic [31:0]          out_score_q;

  logic accept, chan_ok, metric, count_ok, ins_ok;

  assign busy     = state_q != StIdle;
  assign accept   = start && !busy;
  assign chan_ok  = (chan_num_i >= clr_pkg::ChanLow) && (chan_num_i <= clr_pkg::ChanHigh);
  assign metric   = chan_ok && last_probe_i;
  assign count_ok = chan_ok && (scnt_q < CW'(MAX_PROBES));
  assign ins_ok   = count_ok && reply_seen_i && (rcnt_q < CW'(MAX_PROBES));

  // ---------------- sorted sample chain ----------------
  clr_pkg::cell_ctl_t   ctl;
  logic [TIME_BITS-1:0] cval [MAX_PROBES];
  logic                 cgt  [MAX_PROBES];

  assign ctl.ins   = accept && ins_ok;
  assign ctl.shift = state_q == StShift;

  for (genvar i = 0; i < MAX_PROBES; i++) begin : g_cell
    logic [TIME_BITS-1:0] lv, rv;
    logic                 lg;
    if (i == 0) begin : g_first
      assign lv = '0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = cval[i-1];
      assign lg = cgt[i-1];
    end
    if (i == MAX_PROBES - 1) begin : g_last
      assign rv = '0;
    end else begin : g_inner
      assign rv = cval[i+1];
    end
    clr_cell #(.TIME_BITS(TIME_BITS), .CW(CW), .IDX(i)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .cnt_i      (rcnt_q),
      .new_i      (rtt_us_i),
      .left_val_i (lv),
      .left_gt_i  (lg),
      .right_val_i(rv),
      .val_o      (cval[i]),
      .gt_o       (cgt[i])
    );
  end

  // ---------------- percentile indexes ----------------
  logic [PW-1:0] pi_prod;
  logic [CW-1:0] pi_raw, pi_cl;
  logic [IW-1:0] mi, pi;
  logic          shift_end;

  assign pi_prod   = PW'(rcnt_q) * PW'(PctMul);
  assign pi_raw    = CW'(pi_prod >> 19);
  assign pi_cl     = (pi_raw >= rcnt_q) ? (rcnt_q - CW'(1)) : pi_raw;
  assign mi        = IW'(rcnt_q >> 1);
  assign pi        = IW'(pi_cl);
  assign shift_end = (state_q == StShift) && (k_q == pi);

  // ---------------- loss divider ----------------
  logic          div_go, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [DW-1:0] div_den;

  assign div_go  = shift_end;
  assign div_num = NW'(LW'(scnt_q - rcnt_q) * LW'(1000));
  assign div_den = DW'(scnt_q);

  clr_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // ---------------- median weight ----------------
  logic [QW-1:0] mq_prod;

  // med * 30 / 100 as one multiply by the rounded-up fraction, then a shift
  assign mq_prod = QW'(med_q) * QW'(MedWeight);

  // ---------------- score ----------------
  logic [35:0] score_w;
  logic [31:0] score;
  logic        better;

  assign score_w = 36'(p95_q >> 1) + 36'(mq_q) + 36'(loss_q) * 36'(200);
  assign score   = nr_q ? clr_pkg::ScoreMax :
                   ((score_w > 36'(clr_pkg::ScoreMax)) ? clr_pkg::ScoreMax : score_w[31:0]);
  assign better  = score < low_score_q;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept && metric) begin
          state_d = ((rcnt_q + CW'(ins_ok)) == '0) ? StFin : StShift;
        end
      end
      StShift: if (shift_end) state_d = StDivL;
      StDivL:  if (div_done) state_d = StFin;
      StFin:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      scnt_q      <= '0;
      rcnt_q      <= '0;
      low_score_q <= clr_pkg::ScoreMax;
      best_chan_q <= '0;
      k_q         <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= 1'b0;
      if (accept) begin
        k_q <= '0;
        if (!metric && last_channel_i) begin
          // end of run with no metrics: report and drop the run state
          out_vld_q   <= 1'b1;
          scnt_q      <= '0;
          rcnt_q      <= '0;
          low_score_q <= clr_pkg::ScoreMax;
          best_chan_q <= '0;
        end else begin
          // count the probe; keep its time if answered
          if (count_ok) scnt_q <= scnt_q + CW'(1);
          if (ins_ok)   rcnt_q <= rcnt_q + CW'(1);
        end
      end
      if (state_q == StShift) k_q <= k_q + IW'(1);
      if (state_q == StFin) begin
        out_vld_q <= 1'b1;
        scnt_q    <= '0;
        rcnt_q    <= '0;
        if (lastc_q) begin
          low_score_q <= clr_pkg::ScoreMax;
          best_chan_q <= '0;
        end else if (better) begin
          low_score_q <= score;
          best_chan_q <= chan_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chan_q  <= chan_num_i;
      lastc_q <= last_channel_i;
      nr_q    <= (rcnt_q + CW'(ins_ok)) == '0;
      med_q   <= TIME_BITS'(clr_pkg::NoReplyTime);
      p95_q   <= TIME_BITS'(clr_pkg::NoReplyTime);
      loss_q  <= clr_pkg::NoReplyLoss;
      mq_q    <= '0;
      // result for an end-of-run beat without metrics
      out_done_q  <= 1'b1;
      out_best_q  <= best_chan_q;
      out_mchan_q <= '0;
      out_med_q   <= '0;
      out_p95_q   <= '0;
      out_loss_q  <= '0;
      out_score_q <= '0;
    end
    if (state_q == StShift) begin
      if (k_q == mi) med_q <= cval[0];
      if (k_q == pi) p95_q <= cval[0];
    end
    // median is settled once the walk ends; hold its weight while dividing
    if (state_q == StDivL) mq_q <= TIME_BITS'(mq_prod >> KT);
    if ((state_q == StDivL) && div_done) loss_q <= 10'(div_quo);
    if (state_q == StFin) begin
      out_mchan_q <= chan_q;
      out_med_q   <= med_q;
      out_p95_q   <= p95_q;
      out_loss_q  <= loss_q;
      out_score_q <= score;
      out_done_q  <= lastc_q;
      out_best_q  <= lastc_q ? (better ? chan_q : best_chan_q) : 4'd0;
    end
  end

  assign result_valid_o  = out_vld_q;
  assign metric_chan_o   = out_mchan_q;
  assign median_time_o   = out_med_q;
  assign p95_time_o      = out_p95_q;
  assign loss_pm_o       = out_loss_q;
  assign quality_score_o = out_score_q;
  assign run_done_o      = out_done_q;
  assign best_chan_o     = out_best_q;

`ifndef SYNTHESIS
  a_recv_le_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= scnt_q) else $error("receive count exceeds sent count");
  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (rcnt_q != '0)) else $error("percentile walk with no samples");
  a_pick_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |-> (mi <= pi)) else $error("median index above p95 index");
  a_best_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !run_done_o) |-> (best_chan_o == 4'd0))
    else $error("best channel outside run end");
  a_fin_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) |=> result_valid_o) else $error("metric beat without result");
`endif

endmodule
